// ===== rtl/smig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smig_pkg
// Shared widths, register indexes, phase codes and types of the sphere mesh
// index generator.
// ----------------------------------------------------------------------------
package smig_pkg;

    localparam int IDX_W = 17;
    localparam int CNT_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_RINGS_DEF = 256;
    localparam int MAX_SEGMENTS_DEF = 256;

    localparam logic [CNT_W-1:0] RING_COUNT_RESET = 9'd16;
    localparam logic [CNT_W-1:0] SEGMENT_COUNT_RESET = 9'd32;
    localparam logic [CNT_W-1:0] MIN_COUNT = 9'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'd1;

    localparam logic [1:0] PH_BODY = 2'd0;
    localparam logic [1:0] PH_SOUTH = 2'd1;
    localparam logic [1:0] PH_NORTH = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] rings;
        logic [CNT_W-1:0] segments;
        logic [IDX_W-1:0] pole;
        logic [IDX_W-1:0] top;
    } mesh_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic [IDX_W-1:0] third_index;
        logic             last_of_mesh;
    } tri_t;

endpackage
`default_nettype wire

// ===== rtl/smig_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smig_req_if
// Request channel: one transfer asks for one triangle.
// ----------------------------------------------------------------------------
interface smig_req_if;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);

endinterface
`default_nettype wire

// ===== rtl/smig_tri_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smig_tri_if
// Triangle channel: one transfer carries three vertex indices and the
// end-of-mesh flag.
// ----------------------------------------------------------------------------
interface smig_tri_if;
    import smig_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic [IDX_W-1:0] third_index;
    logic             last_of_mesh;

    modport source (output valid, output first_index, output second_index,
                    output third_index, output last_of_mesh, input ready);
    modport sink (input valid, input first_index, input second_index,
                  input third_index, input last_of_mesh, output ready);

endinterface
`default_nettype wire

// ===== rtl/sphere_mesh_index_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator_core
// Triangle index stream of a latitude/longitude sphere mesh.
//
// Each transfer on req asks for one triangle; req.restart set starts over at
// the first body quad. Each request yields exactly one transfer on triangle
// with three vertex indices; last_of_mesh marks the final north fan triangle,
// after which the walk begins again.
// ring_count and segment_count are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while no request is in flight,
// as the block itself does not enforce it. Counts are clamped to 3..MAX.
// A request transfer passes through the request register, then through the
// triangle register loaded from the index logic, before its triangle is
// offered. Throughput is one triangle per cycle while triangle.ready is
// high.
// When triangle.ready is low the triangle register holds; the request
// register still takes one more request, then req.ready drops.
// Reset returns the walk to the first quad and the counts to 16 rings and
// 32 segments; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module sphere_mesh_index_generator_core
    import smig_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    smig_req_if.sink                  req,
    smig_tri_if.source                triangle
);

    mesh_cfg_t cfg;
    tri_t      result;
    tri_t      out_reg;
    logic      in_valid_reg;
    logic      in_restart_reg;
    logic      out_valid_reg;
    logic      move;

    assign move      = in_valid_reg && (!out_valid_reg || triangle.ready);
    assign req.ready = !in_valid_reg || move;

    smig_cfg #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smig_seq #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (!out_valid_reg || triangle.ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            in_restart_reg <= req.restart;
        if (move)
            out_reg <= result;
    end

    assign triangle.valid        = out_valid_reg;
    assign triangle.first_index  = out_reg.first_index;
    assign triangle.second_index = out_reg.second_index;
    assign triangle.third_index  = out_reg.third_index;
    assign triangle.last_of_mesh = out_reg.last_of_mesh;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |-> !req.ready)
        else $error("request register overwritten while held");

    a_move_loads: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("triangle lost between request and result registers");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> req.ready)
        else $error("empty request register refused a transfer");
`endif

endmodule
`default_nettype wire

// ===== rtl/smig_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smig_cfg
// Ring and segment count registers, clamping, and pole and top ring indexes.
// ----------------------------------------------------------------------------
module smig_cfg
    import smig_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    output mesh_cfg_t                 cfg
);

    logic [CNT_W-1:0] ring_count_reg;
    logic [CNT_W-1:0] segment_count_reg;
    logic [CNT_W-1:0] rings;
    logic [CNT_W-1:0] segments;
    logic [IDX_W-1:0] product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= RING_COUNT_RESET;
            segment_count_reg <= SEGMENT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RING_COUNT:    ring_count_reg    <= cfg_data;
                REG_SEGMENT_COUNT: segment_count_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        priority if (ring_count_reg < MIN_COUNT)
            rings = MIN_COUNT;
        else if (32'(ring_count_reg) > MAX_RINGS)
            rings = CNT_W'(MAX_RINGS);
        else
            rings = ring_count_reg;

        priority if (segment_count_reg < MIN_COUNT)
            segments = MIN_COUNT;
        else if (32'(segment_count_reg) > MAX_SEGMENTS)
            segments = CNT_W'(MAX_SEGMENTS);
        else
            segments = segment_count_reg;

        product      = IDX_W'(rings) * IDX_W'(segments);
        cfg.rings    = rings;
        cfg.segments = segments;
        cfg.pole     = product;
        cfg.top      = product - IDX_W'(segments);
    end

endmodule
`default_nettype wire

// ===== rtl/smig_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smig_seq
// Mesh walk state and triangle index formation: body quads, south fan,
// north fan, then wrap to the start.
// ----------------------------------------------------------------------------
module smig_seq
    import smig_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic restart,
    input  mesh_cfg_t cfg,
    output tri_t      result
);

    localparam int RING_W = $clog2(MAX_RINGS);
    localparam int SEG_W = $clog2(MAX_SEGMENTS);

    logic [RING_W-1:0] ring_pos_reg, ring_pos_next, e_ring;
    logic [SEG_W-1:0]  seg_pos_reg, seg_pos_next, e_seg, s1;
    logic              half_reg, half_next, e_half;
    logic [1:0]        phase_reg, phase_next, e_phase;
    logic [IDX_W-1:0]  base_reg, base_next, e_base;
    logic              do_restart;
    logic              seg_end;
    logic              ring_end;
    logic [IDX_W-1:0]  sx, s1x, ssx;

    always_comb
    begin
        do_restart = restart || (phase_reg == PH_UNUSED);
        e_ring  = do_restart ? '0 : ring_pos_reg;
        e_seg   = do_restart ? '0 : seg_pos_reg;
        e_half  = do_restart ? 1'b0 : half_reg;
        e_phase = do_restart ? PH_BODY : phase_reg;
        e_base  = do_restart ? '0 : base_reg;

        seg_end  = 32'(e_seg) >= 32'(cfg.segments) - 32'd1;
        ring_end = 32'(e_ring) >= 32'(cfg.rings) - 32'd2;
        s1       = seg_end ? '0 : e_seg + 1'b1;
        sx       = IDX_W'(e_seg);
        s1x      = IDX_W'(s1);
        ssx      = IDX_W'(cfg.segments);

        ring_pos_next = e_ring;
        seg_pos_next  = e_seg;
        half_next     = e_half;
        phase_next    = e_phase;
        base_next     = e_base;
        result        = '0;

        unique case (e_phase)
            PH_BODY:
            begin
                result.first_index = e_base + sx;
                if (!e_half)
                begin
                    result.second_index = e_base + ssx + s1x;
                    result.third_index  = e_base + ssx + sx;
                    half_next = 1'b1;
                end
                else
                begin
                    result.second_index = e_base + s1x;
                    result.third_index  = e_base + ssx + s1x;
                    half_next = 1'b0;
                    seg_pos_next = s1;
                    if (seg_end)
                    begin
                        if (ring_end)
                        begin
                            phase_next    = PH_SOUTH;
                            ring_pos_next = '0;
                            base_next     = '0;
                        end
                        else
                        begin
                            ring_pos_next = e_ring + 1'b1;
                            base_next     = e_base + ssx;
                        end
                    end
                end
            end
            PH_SOUTH:
            begin
                result.first_index  = sx;
                result.second_index = cfg.pole;
                result.third_index  = s1x;
                seg_pos_next = s1;
                if (seg_end)
                    phase_next = PH_NORTH;
            end
            PH_NORTH:
            begin
                result.first_index  = cfg.top + sx;
                result.second_index = cfg.top + s1x;
                result.third_index  = cfg.pole + 1'b1;
                seg_pos_next = s1;
                if (seg_end)
                begin
                    result.last_of_mesh = 1'b1;
                    ring_pos_next = '0;
                    half_next     = 1'b0;
                    phase_next    = PH_BODY;
                    base_next     = '0;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_pos_reg <= '0;
            seg_pos_reg  <= '0;
            half_reg     <= 1'b0;
            phase_reg    <= PH_BODY;
            base_reg     <= '0;
        end
        else if (step)
        begin
            ring_pos_reg <= ring_pos_next;
            seg_pos_reg  <= seg_pos_next;
            half_reg     <= half_next;
            phase_reg    <= phase_next;
            base_reg     <= base_next;
        end
    end

`ifndef SYNTHESIS
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.last_of_mesh |=>
            phase_reg == PH_BODY && seg_pos_reg == '0 && base_reg == '0 && !half_reg)
        else $error("mesh end did not return to the first quad");

    a_half_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        step && e_phase == PH_BODY && !e_half |=> half_reg && seg_pos_reg == $past(e_seg))
        else $error("first quad half did not advance to the second");

    a_south_to_north: assert property (@(posedge clk) disable iff (!rst_n)
        step && e_phase == PH_SOUTH && seg_end |=> phase_reg == PH_NORTH && seg_pos_reg == '0)
        else $error("south fan end did not enter the north fan");
`endif

endmodule
`default_nettype wire

// ===== tb/sphere_mesh_index_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator_core_tb
// Drives triangle requests into the sphere mesh index generator and checks
// every returned triangle against a cycle-free model of the ring/segment
// walk. Covers reset counts, the smallest mesh through its wrap, forced restarts,
// clamped and changed counts between bursts, pole indices at the full
// 256 x 256 size, random request/response idling and a back-to-back stretch.
// ----------------------------------------------------------------------------
module sphere_mesh_index_generator_core_tb;
    import smig_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_TARGET = 1050;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    smig_req_if req();
    smig_tri_if triangle();

    sphere_mesh_index_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .triangle  (triangle)
    );

    // walk state and count registers as the block should hold them
    logic [CNT_W-1:0] ring_cfg;
    logic [CNT_W-1:0] seg_cfg;
    logic [7:0]       ring_pos;
    logic [7:0]       seg_pos;
    logic             quad_second;
    logic [1:0]       walk_phase;
    logic [IDX_W-1:0] ring_first;

    tri_t expected_tris[$];
    int   errors = 0;
    int   requests_sent = 0;
    int   cfg_writes = 0;
    bit   idle_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned clamped(input logic [CNT_W-1:0] v, input int unsigned hi);
        if (v < MIN_COUNT)
            return 32'(MIN_COUNT);
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic void restart_walk();
        ring_pos = '0;
        seg_pos = '0;
        quad_second = 1'b0;
        walk_phase = PH_BODY;
        ring_first = '0;
    endfunction

    function automatic tri_t next_triangle(input logic rs);
        int unsigned rr;
        int unsigned ss;
        int unsigned pole;
        int unsigned s;
        int unsigned s1;
        int unsigned top;
        bit          seg_end;
        tri_t        t;
        rr = clamped(ring_cfg, MAX_RINGS_DEF);
        ss = clamped(seg_cfg, MAX_SEGMENTS_DEF);
        pole = rr * ss;
        if (rs || walk_phase == PH_UNUSED)
            restart_walk();
        s = 32'(seg_pos);
        seg_end = (s >= ss - 1);
        s1 = seg_end ? 0 : s + 1;
        t.last_of_mesh = 1'b0;
        case (walk_phase)
            PH_BODY:
            begin
                if (!quad_second)
                begin
                    t.first_index = IDX_W'(ring_first + s);
                    t.second_index = IDX_W'(ring_first + ss + s1);
                    t.third_index = IDX_W'(ring_first + ss + s);
                    quad_second = 1'b1;
                end
                else
                begin
                    t.first_index = IDX_W'(ring_first + s);
                    t.second_index = IDX_W'(ring_first + s1);
                    t.third_index = IDX_W'(ring_first + ss + s1);
                    quad_second = 1'b0;
                    if (seg_end)
                    begin
                        seg_pos = '0;
                        if (ring_pos >= rr - 2)
                        begin
                            walk_phase = PH_SOUTH;
                            ring_pos = '0;
                            ring_first = '0;
                        end
                        else
                        begin
                            ring_pos = 8'(ring_pos + 1);
                            ring_first = IDX_W'(ring_first + ss);
                        end
                    end
                    else
                        seg_pos = 8'(s + 1);
                end
            end
            PH_SOUTH:
            begin
                t.first_index = IDX_W'(s);
                t.second_index = IDX_W'(pole);
                t.third_index = IDX_W'(s1);
                if (seg_end)
                begin
                    seg_pos = '0;
                    walk_phase = PH_NORTH;
                end
                else
                    seg_pos = 8'(s + 1);
            end
            default:
            begin
                top = (rr - 1) * ss;
                t.first_index = IDX_W'(top + s);
                t.second_index = IDX_W'(top + s1);
                t.third_index = IDX_W'(pole + 1);
                if (seg_end)
                begin
                    t.last_of_mesh = 1'b1;
                    restart_walk();
                end
                else
                    seg_pos = 8'(s + 1);
            end
        endcase
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        logic [CNT_W-1:0] odd_counts[8] = '{9'd0, 9'd1, 9'd2, 9'd3,
                                            9'd255, 9'd256, 9'd257, 9'd511};
        if ($urandom_range(0, 9) == 0)
            return odd_counts[$urandom_range(0, 7)];
        return CNT_W'($urandom_range(3, 8));
    endfunction

    task automatic check_field(input string name, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_triangles
        tri_t want;
        if (rst_n && triangle.valid && triangle.ready)
        begin
            if (expected_tris.size() == 0)
            begin
                $error("triangle transfer with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_tris.pop_front();
                check_field("first_index", want.first_index, triangle.first_index);
                check_field("second_index", want.second_index, triangle.second_index);
                check_field("third_index", want.third_index, triangle.third_index);
                check_field("last_of_mesh", IDX_W'(want.last_of_mesh),
                            IDX_W'(triangle.last_of_mesh));
            end
        end
    end

    initial
    begin : triangle_sink
        triangle.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                triangle.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            triangle.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (triangle.valid && triangle.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(input logic rs);
        tri_t want_tri;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.restart <= rs;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        want_tri = next_triangle(rs);
        expected_tris = {expected_tris, want_tri};
        requests_sent++;
    endtask

    task automatic drain_pipeline();
        req.valid <= 1'b0;
        while (expected_tris.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_counts(input bit wr_rings, input logic [CNT_W-1:0] rings,
                              input bit wr_segs, input logic [CNT_W-1:0] segs);
        drain_pipeline();
        if (wr_rings)
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_RING_COUNT;
            cfg_data <= rings;
            @(posedge clk);
            ring_cfg = rings;
            cfg_writes++;
        end
        if (wr_segs)
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_SEGMENT_COUNT;
            cfg_data <= segs;
            @(posedge clk);
            seg_cfg = segs;
            cfg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_counts();
        repeat (2) send_request(1'b0);
    endtask

    task automatic test_minimal_mesh();
        set_counts(1'b1, 9'd3, 1'b1, 9'd3);
        repeat (19) send_request(1'b0);
    endtask

    task automatic test_forced_restart();
        repeat (2) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_random_walks();
        int mode;
        while (requests_sent < RANDOM_TARGET)
        begin
            mode = $urandom_range(0, 3);
            if (mode != 3)
                set_counts(mode != 2, pick_count(), mode != 1, pick_count());
            repeat ($urandom_range(8, 60)) send_request($urandom_range(0, 49) == 0);
        end
    endtask

    task automatic test_reconfigure_mid_mesh();
        set_counts(1'b1, 9'd3, 1'b1, 9'd3);
        send_request(1'b1);
        repeat (11) send_request(1'b0);
        set_counts(1'b1, 9'd511, 1'b1, 9'd300);
        repeat (10) send_request(1'b0);
        set_counts(1'b0, '0, 1'b1, 9'd3);
        send_request(1'b0);
        set_counts(1'b0, '0, 1'b1, 9'd256);
        repeat (10) send_request(1'b0);
        set_counts(1'b0, '0, 1'b1, 9'd4);
        repeat (3) send_request(1'b0);
        set_counts(1'b1, 9'd16, 1'b1, 9'd4);
        send_request(1'b1);
        repeat (39) send_request(1'b0);
        set_counts(1'b1, 9'd3, 1'b0, '0);
        repeat (20) send_request(1'b0);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_counts(1'b1, 9'd5, 1'b1, 9'd4);
        repeat (400) send_request($urandom_range(0, 99) == 0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_RING_COUNT;
        cfg_data <= '0;
        req.valid <= 1'b0;
        req.restart <= 1'b0;
        ring_cfg = RING_COUNT_RESET;
        seg_cfg = SEGMENT_COUNT_RESET;
        restart_walk();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_counts();
        test_minimal_mesh();
        test_forced_restart();
        test_random_walks();
        test_reconfigure_mid_mesh();
        test_back_to_back();

        drain_pipeline();
        repeat (10) @(posedge clk);
        $display("Sent %0d triangle requests around %0d count writes: reset and clamped counts,",
                 requests_sent, cfg_writes);
        $display("full walks with wrap, pole fans at 256 x 256, restarts and mid-mesh changes.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
